// ===== rtl/wtp_pkg.sv =====
// Package for the weather telegram parser: frame layout, field table,
// ASCII codes and the per-field parse phase type. No dependencies.
package wtp_pkg;

  localparam int unsigned FRAME_LENGTH = 40;
  localparam int unsigned SUM_END      = 35;
  localparam int unsigned FIELD_COUNT  = 7;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned FLD_W        = 3;
  localparam int unsigned ACC_W        = 14;
  localparam int unsigned SUM_W        = 14;
  localparam int unsigned TEMP_W       = 11;
  localparam int unsigned SUN_W        = 7;
  localparam int unsigned LVL_W        = 10;
  localparam int unsigned LIGHT_W      = 17;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned OUT_DATA_W   = 104;

  localparam logic [ACC_W-1:0] ACC_MAX     = ACC_W'(16383);
  localparam logic [LVL_W-1:0] TENTHS_MAX  = LVL_W'(999);
  localparam logic [SUN_W-1:0] SUN_MAX     = SUN_W'(99);
  localparam logic [LVL_W-1:0] DAY_MAX     = LVL_W'(999);
  localparam logic [CNT_W-1:0] DECIM_RESET = CNT_W'(5);

  localparam logic [POS_W-1:0] POS_DAWN = POS_W'(12);
  localparam logic [POS_W-1:0] POS_RAIN = POS_W'(20);

  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // field index: temperature, south, west, east, daylight, wind, checksum
  localparam logic [FLD_W-1:0] FLD_TEMP  = FLD_W'(0);
  localparam logic [FLD_W-1:0] FLD_SOUTH = FLD_W'(1);
  localparam logic [FLD_W-1:0] FLD_WEST  = FLD_W'(2);
  localparam logic [FLD_W-1:0] FLD_EAST  = FLD_W'(3);
  localparam logic [FLD_W-1:0] FLD_DAY   = FLD_W'(4);
  localparam logic [FLD_W-1:0] FLD_WIND  = FLD_W'(5);
  localparam logic [FLD_W-1:0] FLD_CSUM  = FLD_W'(6);

  localparam logic [POS_W-1:0] FLD_START [FIELD_COUNT] = '{
    POS_W'(1), POS_W'(6), POS_W'(8), POS_W'(10), POS_W'(13), POS_W'(16), POS_W'(35)
  };
  localparam logic [POS_W-1:0] FLD_LEN [FIELD_COUNT] = '{
    POS_W'(5), POS_W'(2), POS_W'(2), POS_W'(2), POS_W'(3), POS_W'(4), POS_W'(4)
  };

  typedef struct packed {
    logic neg;
    logic fracdone;
    logic frac;
    logic ended;
    logic started;
  } wtp_phase_t;

  typedef struct packed {
    logic             hit;
    logic [FLD_W-1:0] idx;
  } wtp_sel_t;

  function automatic wtp_sel_t wtp_field_sel(input logic [POS_W-1:0] pos);
    wtp_sel_t s;
    s = '0;
    for (int unsigned k = 0; k < FIELD_COUNT; k++) begin
      if (pos >= FLD_START[k] && pos < FLD_START[k] + FLD_LEN[k]) begin
        s.hit = 1'b1;
        s.idx = FLD_W'(k);
      end
    end
    return s;
  endfunction

  function automatic logic wtp_is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [LVL_W-1:0] wtp_tenths(input logic [ACC_W-1:0] acc,
                                                  input logic fracdone);
    logic [17:0] v;
    v = fracdone ? 18'(acc) : (18'(acc) << 3) + (18'(acc) << 1);
    return (v > 18'(TENTHS_MAX)) ? TENTHS_MAX : v[LVL_W-1:0];
  endfunction

endpackage

// ===== rtl/weather_telegram_parser.sv =====
// Weather telegram parser top level: byte stream in, decoded telegram out.
// Depends on wtp_pkg.
//
// Usage:
//   in_*  : one telegram byte per word, tlast on the last byte of a burst.
//   out_* : one decoded telegram per emitted burst; tuser carries status.
//   cfg_* : decimation limit, written while the block is idle.
// A burst gives a result only when the burst counter, before counting this
// burst, exceeds the decimation limit; the counter then returns to zero.
// Every burst end clears the frame state. A burst shorter than 40 bytes
// reports status 1 with all fields zero; a checksum mismatch reports status 1
// with only the two sums filled in. Bytes past 40 are ignored.
// Throughput: one byte per cycle, except for the receiver stall described below. A
// byte is held in the input register; the result word is registered as the last
// byte leaves it, and out_tvalid rises with it.
// Reset clears the frame state and burst counter and sets the limit to 5.
// When the receiver stalls, the input register holds only a burst end that
// would emit; all other bytes keep flowing.
module weather_telegram_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // burst_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // temperature_tenths, south_level, west_level, east_level,
                                   // dawn_flag, daylight_level, wind_tenths, rain_flag,
                                   // light_sum, computed_sum, received_sum, zero pad
  output logic         out_tuser,  // status
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata   // decimation_limit
);
  import wtp_pkg::*;

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ACC_W-1:0]    acc_r [FIELD_COUNT];
  logic [ACC_W-1:0]    acc_nxt [FIELD_COUNT];
  wtp_phase_t          ph_r [FIELD_COUNT];
  wtp_phase_t          ph_nxt [FIELD_COUNT];
  logic                dawn_r, dawn_nxt, rain_r, rain_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    limit_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                out_status_r, out_status_nxt;

  logic                emit, out_free, s1_adv;
  wtp_sel_t            sel;
  logic [ACC_W-1:0]    f_acc;
  wtp_phase_t          f_ph, f_ph_nxt;
  logic [ACC_W-1:0]    f_acc_nxt;
  logic [17:0]         acc_x10;
  logic                is_digit, dec_ok;

  logic                full, rneg, sum_ok;
  logic [LVL_W-1:0]    t_mag, wind, day;
  logic [TEMP_W-1:0]   temp;
  logic [SUN_W-1:0]    south, west, east;
  logic [LIGHT_W-1:0]  light;

  function automatic logic [SUN_W-1:0] sun_of(input logic [ACC_W-1:0] acc,
                                               input wtp_phase_t ph);
    if (ph.neg) return '0;
    return (acc > ACC_W'(SUN_MAX)) ? SUN_MAX : acc[SUN_W-1:0];
  endfunction

  assign emit      = s1_last_r && (cnt_r > limit_r);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // one field parser, shared: fields never overlap
  assign sel      = wtp_field_sel(pos_r);
  assign f_acc    = acc_r[sel.idx];
  assign f_ph     = ph_r[sel.idx];
  assign is_digit = (s1_byte_r >= CH_0) && (s1_byte_r <= CH_9);
  assign dec_ok   = (sel.idx == FLD_TEMP) || (sel.idx == FLD_WIND);
  assign acc_x10  = (18'(f_acc) << 3) + (18'(f_acc) << 1) + 18'(s1_byte_r[3:0]);

  always_comb begin
    f_ph_nxt  = f_ph;
    f_acc_nxt = f_acc;
    if (!f_ph.ended) begin
      if (is_digit) begin
        f_ph_nxt.started = 1'b1;
        if (!f_ph.frac || !f_ph.fracdone) begin
          f_acc_nxt = (acc_x10 > 18'(ACC_MAX)) ? ACC_MAX : acc_x10[ACC_W-1:0];
        end
        if (f_ph.frac) begin
          f_ph_nxt.fracdone = 1'b1;
        end
      end else if (!f_ph.started && wtp_is_space(s1_byte_r)) begin
        f_ph_nxt = f_ph;
      end else if (!f_ph.started && (s1_byte_r == CH_PLUS || s1_byte_r == CH_MINUS)) begin
        f_ph_nxt.started = 1'b1;
        f_ph_nxt.neg     = (s1_byte_r == CH_MINUS);
      end else if (s1_byte_r == CH_DOT && dec_ok && !f_ph.frac) begin
        f_ph_nxt.frac    = 1'b1;
        f_ph_nxt.started = 1'b1;
      end else begin
        f_ph_nxt.ended = 1'b1;
      end
    end
  end

  // result from the stored frame: a full frame's last byte lies past every field
  assign full   = (pos_r >= POS_W'(FRAME_LENGTH - 1));
  assign rneg   = ph_r[FLD_CSUM].neg;
  assign sum_ok = rneg ? (acc_r[FLD_CSUM] == '0 && sum_r == '0)
                       : (acc_r[FLD_CSUM] == sum_r);
  assign t_mag  = wtp_tenths(acc_r[FLD_TEMP], ph_r[FLD_TEMP].fracdone);
  assign temp   = ph_r[FLD_TEMP].neg ? TEMP_W'(-$signed({1'b0, t_mag})) : TEMP_W'(t_mag);
  assign south  = sun_of(acc_r[FLD_SOUTH], ph_r[FLD_SOUTH]);
  assign west   = sun_of(acc_r[FLD_WEST], ph_r[FLD_WEST]);
  assign east   = sun_of(acc_r[FLD_EAST], ph_r[FLD_EAST]);
  assign day    = ph_r[FLD_DAY].neg ? '0 :
                  (acc_r[FLD_DAY] > ACC_W'(DAY_MAX)) ? DAY_MAX : acc_r[FLD_DAY][LVL_W-1:0];
  assign wind   = ph_r[FLD_WIND].neg ? '0 :
                  wtp_tenths(acc_r[FLD_WIND], ph_r[FLD_WIND].fracdone);
  assign light  = LIGHT_W'(south) * LIGHT_W'(1000) + LIGHT_W'(day);

  always_comb begin
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    ph_nxt         = ph_r;
    dawn_nxt       = dawn_r;
    rain_nxt       = rain_r;
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    if (s1_adv) begin
      if (pos_r < POS_W'(FRAME_LENGTH)) begin
        if (pos_r < POS_W'(SUM_END)) begin
          sum_nxt = sum_r + SUM_W'(s1_byte_r);
        end
        if (pos_r == POS_DAWN && s1_byte_r == CH_J) dawn_nxt = 1'b1;
        if (pos_r == POS_RAIN && s1_byte_r == CH_J) rain_nxt = 1'b1;
        if (sel.hit) begin
          acc_nxt[sel.idx] = f_acc_nxt;
          ph_nxt[sel.idx]  = f_ph_nxt;
        end
        pos_nxt = pos_r + POS_W'(1);
      end
      if (s1_last_r) begin
        cnt_nxt = emit ? '0 : cnt_r + CNT_W'(1);
        if (emit) begin
          out_data_nxt   = '0;
          out_status_nxt = 1'b1;
          if (full) begin
            out_data_nxt[84:71] = sum_r;
            out_data_nxt[98:85] = acc_r[FLD_CSUM];
            if (sum_ok) begin
              out_status_nxt      = 1'b0;
              out_data_nxt[10:0]  = temp;
              out_data_nxt[17:11] = south;
              out_data_nxt[24:18] = west;
              out_data_nxt[31:25] = east;
              out_data_nxt[32]    = dawn_r;
              out_data_nxt[42:33] = day;
              out_data_nxt[52:43] = wind;
              out_data_nxt[53]    = rain_r;
              out_data_nxt[70:54] = light;
            end
          end
        end
        pos_nxt  = '0;
        sum_nxt  = '0;
        dawn_nxt = 1'b0;
        rain_nxt = 1'b0;
        for (int unsigned k = 0; k < FIELD_COUNT; k++) begin
          acc_nxt[k] = '0;
          ph_nxt[k]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      sum_r       <= '0;
      dawn_r      <= 1'b0;
      rain_r      <= 1'b0;
      cnt_r       <= '0;
      limit_r     <= DECIM_RESET;
      for (int unsigned k = 0; k < FIELD_COUNT; k++) begin
        acc_r[k] <= '0;
        ph_r[k]  <= '0;
      end
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      dawn_r <= dawn_nxt;
      rain_r <= rain_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      ph_r   <= ph_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(FRAME_LENGTH))
    else $error("byte position past frame length");

  a_burst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> pos_r == '0 && sum_r == '0)
    else $error("frame state not cleared at burst end");

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit |=> cnt_r == '0 && out_valid_r)
    else $error("emitted burst did not reset counter or raise valid");

  a_ok_sums: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_status_r |-> out_data_r[84:71] == out_data_r[98:85])
    else $error("status ok with mismatched sums");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && emit && out_valid_r)
    else $error("input stalled without a pending result");
`endif

endmodule

// ===== dv/tb_weather_telegram_parser.sv =====
`timescale 1ns / 1ps
// Testbench for weather_telegram_parser: random-gapped telegram byte stream with back-pressure,
// a scoreboard that predicts each decoded telegram and checks it field by field.
// Depends on wtp_pkg and the weather_telegram_parser RTL.
module tb_weather_telegram_parser;
  import wtp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned ITEM_TARGET    = 850;
  localparam int unsigned IDLE_PCT       = 35;

  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FILL = 8'h23;
  localparam logic [7:0] CH_TAIL = 8'h58;

  typedef logic [7:0] burst_t[$];

  typedef struct {
    logic               status;
    logic [TEMP_W-1:0]  temp;
    logic [SUN_W-1:0]   south;
    logic [SUN_W-1:0]   west;
    logic [SUN_W-1:0]   east;
    logic               dawn;
    logic [LVL_W-1:0]   day;
    logic [LVL_W-1:0]   wind;
    logic               rain;
    logic [LIGHT_W-1:0] light;
    logic [SUM_W-1:0]   csum;
    logic [SUM_W-1:0]   rsum;
  } telegram_t;

  class telegram_scoreboard;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] burst_cnt;
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] sum;
    logic [ACC_W-1:0] acc [FIELD_COUNT];
    wtp_phase_t       ph [FIELD_COUNT];
    logic             dawn;
    logic             rain;
    telegram_t        telegrams_due[$];
    int unsigned      errors;

    function new();
      limit     = DECIM_RESET;
      burst_cnt = '0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos  = '0;
      sum  = '0;
      dawn = 1'b0;
      rain = 1'b0;
      foreach (acc[k]) begin
        acc[k] = '0;
        ph[k]  = '0;
      end
    endfunction

    function void push_digit(int k, int unsigned d);
      int unsigned v;
      v = acc[k] * 10 + d;
      acc[k] = (v > ACC_MAX) ? ACC_MAX : ACC_W'(v);
    endfunction

    // atoi/atof style scan: skip leading blanks, one sign, digits, one '.' in decimal fields
    function void feed(int k, logic [7:0] b);
      wtp_phase_t s;
      s = ph[k];
      if (s.ended) return;
      if (b >= CH_0 && b <= CH_9) begin
        s.started = 1'b1;
        if (!s.frac || !s.fracdone) push_digit(k, 32'(b - CH_0));
        if (s.frac) s.fracdone = 1'b1;
      end else if (!s.started && (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
      end else if (!s.started && (b == CH_PLUS || b == CH_MINUS)) begin
        s.started = 1'b1;
        if (b == CH_MINUS) s.neg = 1'b1;
      end else if (b == CH_DOT && (k == FLD_TEMP || k == FLD_WIND) && !s.frac) begin
        s.frac    = 1'b1;
        s.started = 1'b1;
      end else begin
        s.ended = 1'b1;
      end
      ph[k] = s;
    endfunction

    function int unsigned tenths(int k);
      int unsigned v;
      v = 32'(acc[k]);
      if (!ph[k].fracdone) v = v * 10;
      return (v > TENTHS_MAX) ? TENTHS_MAX : v;
    endfunction

    function int unsigned level(int k, int unsigned cap);
      if (ph[k].neg) return 0;
      return (acc[k] > cap) ? cap : 32'(acc[k]);
    endfunction

    function void note_word(logic [7:0] b, logic last);
      int unsigned      p;
      logic [CNT_W-1:0] c;
      logic             ok;
      telegram_t        t;
      p = pos;
      if (p < FRAME_LENGTH) begin
        if (p < SUM_END) sum = sum + SUM_W'(b);
        if (p == POS_DAWN && b == CH_J) dawn = 1'b1;
        if (p == POS_RAIN && b == CH_J) rain = 1'b1;
        for (int k = 0; k < FIELD_COUNT; k++)
          if (p >= int'(FLD_START[k]) && p < int'(FLD_START[k]) + int'(FLD_LEN[k])) feed(k, b);
        pos = POS_W'(p + 1);
      end
      if (!last) return;
      c = burst_cnt;
      burst_cnt = c + 1'b1;
      if (c <= limit) begin
        clear_frame();
        return;
      end
      burst_cnt = '0;
      t = '{default: '0};
      if (pos < FRAME_LENGTH) begin
        t.status = 1'b1;
      end else begin
        ok = ph[FLD_CSUM].neg ? (acc[FLD_CSUM] == 0 && sum == 0) : (acc[FLD_CSUM] == sum);
        t.csum = sum;
        t.rsum = acc[FLD_CSUM];
        if (!ok) begin
          t.status = 1'b1;
        end else begin
          t.temp  = ph[FLD_TEMP].neg ? TEMP_W'(-int'(tenths(FLD_TEMP)))
                                     : TEMP_W'(tenths(FLD_TEMP));
          t.south = SUN_W'(level(FLD_SOUTH, SUN_MAX));
          t.west  = SUN_W'(level(FLD_WEST, SUN_MAX));
          t.east  = SUN_W'(level(FLD_EAST, SUN_MAX));
          t.dawn  = dawn;
          t.day   = LVL_W'(level(FLD_DAY, DAY_MAX));
          t.wind  = ph[FLD_WIND].neg ? '0 : LVL_W'(tenths(FLD_WIND));
          t.rain  = rain;
          t.light = LIGHT_W'(t.south * 1000 + t.day);
        end
      end
      telegrams_due.push_back(t);
      clear_frame();
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_telegram(logic [OUT_DATA_W-1:0] d, logic status);
      telegram_t t;
      if (telegrams_due.size() == 0) begin
        $error("decoded telegram word with no telegram predicted");
        errors++;
        return;
      end
      t = telegrams_due.pop_front();
      compare("status", 32'(t.status), 32'(status));
      compare("temperature_tenths", 32'(t.temp), 32'(d[10:0]));
      compare("south_level", 32'(t.south), 32'(d[17:11]));
      compare("west_level", 32'(t.west), 32'(d[24:18]));
      compare("east_level", 32'(t.east), 32'(d[31:25]));
      compare("dawn_flag", 32'(t.dawn), 32'(d[32]));
      compare("daylight_level", 32'(t.day), 32'(d[42:33]));
      compare("wind_tenths", 32'(t.wind), 32'(d[52:43]));
      compare("rain_flag", 32'(t.rain), 32'(d[53]));
      compare("light_sum", 32'(t.light), 32'(d[70:54]));
      compare("computed_sum", 32'(t.csum), 32'(d[84:71]));
      compare("received_sum", 32'(t.rsum), 32'(d[98:85]));
    endfunction

    function int unsigned pending();
      return telegrams_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [7:0]            cfg_wdata;

  telegram_scoreboard sb = new();
  bit                 quiet;
  bit                 hold_req;
  int unsigned        bytes_sent;
  int unsigned        stall_cycles;

  weather_telegram_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_telegram(out_tdata, out_tuser);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[weather_telegram_parser] ERROR");
    $finish;
  end

  // result side: random stalls, long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic put_word(logic [7:0] b, logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_burst(burst_t f);
    foreach (f[i]) put_word(f[i], i == f.size() - 1);
    bytes_sent += f.size();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  function automatic burst_t text(string s);
    burst_t f;
    for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
    return f;
  endfunction

  // pad the head to 35 bytes, append its decimal checksum and a tail byte
  function automatic burst_t seal(burst_t f);
    int unsigned s;
    string       cs;
    s = 0;
    while (f.size() < SUM_END) f.push_back(CH_FILL);
    foreach (f[i]) s += f[i];
    cs = $sformatf("%04d", s);
    for (int i = 0; i < 4; i++) f.push_back(cs[i]);
    f.push_back(CH_TAIL);
    return f;
  endfunction

  function automatic burst_t noise_burst(int unsigned n);
    burst_t f;
    repeat (n) f.push_back(8'($urandom_range(255)));
    return f;
  endfunction

  function automatic logic [7:0] digit();
    return 8'(CH_0 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(9))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_VT;
      4: return CH_PLUS;
      5: return CH_MINUS;
      6: return CH_DOT;
      7: return CH_E;
      8: return CH_J;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic burst_t random_telegram();
    burst_t      f;
    int unsigned s;
    string       cs;
    s = 0;
    f = noise_burst(FRAME_LENGTH);
    case ($urandom_range(3))
      0: f[1] = CH_PLUS;
      1: f[1] = CH_MINUS;
      2: f[1] = CH_SPACE;
      default: f[1] = digit();
    endcase
    f[2] = digit();
    f[3] = digit();
    f[4] = CH_DOT;
    f[5] = digit();
    for (int i = 6; i < 12; i++) f[i] = digit();
    f[12] = $urandom_range(1) ? CH_J : CH_N;
    for (int i = 13; i < 18; i++) f[i] = digit();
    f[18] = CH_DOT;
    f[19] = digit();
    f[20] = $urandom_range(1) ? CH_J : CH_N;
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3)) f[$urandom_range(1, 20)] = odd_byte();
    for (int i = 0; i < SUM_END; i++) s += f[i];
    cs = $urandom_range(3) ? $sformatf("%04d", s) : $sformatf("%4d", s);
    for (int i = 0; i < 4; i++) f[SUM_END + i] = cs[i];
    if ($urandom_range(99) < 15) f[$urandom_range(38)] ^= 8'(1 << $urandom_range(7));
    if ($urandom_range(99) < 5) f[SUM_END] = CH_MINUS;
    return f;
  endfunction

  function automatic burst_t random_burst();
    burst_t      f;
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 60) begin
      f = random_telegram();
      if ($urandom_range(9) == 0) f = {f, noise_burst($urandom_range(1, 6))};
    end else if (r < 80) begin
      f = random_telegram();
      n = $urandom_range(1, FRAME_LENGTH - 1);
      while (f.size() > n) void'(f.pop_back());
    end else begin
      f = noise_burst($urandom_range(1, 3));
    end
    return f;
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'd0;
      4, 5:       return 8'd1;
      6:          return 8'd2;
      7:          return 8'd3;
      8:          return DECIM_RESET;
      default:    return 8'($urandom_range(6, 254));
    endcase
  endfunction

  // one throwaway burst first, so that with a limit of 0 the telegram is decoded
  task automatic decode(burst_t f);
    send_burst(noise_burst(1));
    send_burst(f);
  endtask

  initial begin
    burst_t      f;
    burst_t      full;
    int unsigned phase_cnt;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limit: the seventh burst is the first to be decoded
    repeat (7) send_burst(noise_burst(1));

    write_limit(8'd0);
    full = seal(text("W+99.9999999J99999.9J"));
    decode(full);
    decode(seal(text("W-99.9000000N00000.0N")));
    decode(seal(text("W 1234-1-9 7J-12-1.5x")));
    decode(seal(text("W12.34+5 +07J 4299.x.")));
    decode(seal(text("W\t-3. \n4\0134\0155j  9+.5eJ")));

    // no gaps on either side for the rest of the directed telegrams
    quiet = 1'b1;
    f = full;
    f[38] ^= 8'h01;
    decode(f);
    f = full;
    f[SUM_END] = CH_MINUS;
    decode(f);
    f = full;
    while (f.size() > 10) void'(f.pop_back());
    decode(f);
    f = {full, noise_burst(5)};
    decode(f);
    f = {};
    repeat (SUM_END) f.push_back(8'h00);
    f = seal(f);
    f[SUM_END] = CH_MINUS;
    decode(f);
    f = {};
    repeat (SUM_END) f.push_back(8'hFF);
    decode(seal(f));
    quiet = 1'b0;

    // receiver holds off while short bursts keep coming
    write_limit(8'd0);
    hold_req = 1'b1;
    repeat (40) send_burst(noise_burst($urandom_range(1, 2)));

    // counter wraps past 255 without a result
    write_limit(8'd255);
    repeat (260) send_burst(noise_burst(1));

    // random traffic, a fresh limit per phase, until the byte budget is spent
    phase_cnt = 0;
    while (bytes_sent < ITEM_TARGET) begin
      write_limit(phase_cnt == 0 ? 8'd0 : pick_limit());
      repeat ($urandom_range(1, 3)) send_burst(random_burst());
      phase_cnt++;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[weather_telegram_parser] OK");
    else
      $display("[weather_telegram_parser] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wtp_pkg.sv
rtl/weather_telegram_parser.sv
dv/tb_weather_telegram_parser.sv
